// ----- design/ltbr_pkg.sv -----
package ltbr_pkg;

	localparam int VideoWordsDef   = 24576;
	localparam int LineWidthDef    = 240;
	localparam int VisibleLinesDef = 160;
	localparam int TotalLinesDef   = 228;
	localparam int SmallWords      = 256;
	localparam int PageBytes       = 'hA000;

	localparam logic [2:0] CMD_READ   = 3'd0;
	localparam logic [2:0] CMD_WRITE  = 3'd1;
	localparam logic [2:0] CMD_LSTART = 3'd2;
	localparam logic [2:0] CMD_HBLANK = 3'd3;
	localparam logic [2:0] CMD_LFIN   = 3'd4;
	localparam logic [2:0] CMD_PIXEL  = 3'd5;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_ADDR  = 2'd1;
	localparam logic [1:0] ERR_MODE  = 2'd2;
	localparam logic [1:0] ERR_UNSUP = 2'd3;

	localparam logic [2:0] REG_VIDEO = 3'd6;
	localparam logic [2:0] REG_PAL   = 3'd5;
	localparam logic [2:0] REG_OBJ   = 3'd7;
	localparam logic [2:0] REG_IO    = 3'd4;

	// what stage 1 hands to stage 2 for the read-data merge
	typedef struct packed {
		logic [2:0] sel;   // 0 none, 1 video, 2 palette, 3 object, 4 direct
		logic [1:0] lane;
		logic [2:0] bytes;
	} rd_ctl_t;

	localparam logic [2:0] SEL_NONE = 3'd0;
	localparam logic [2:0] SEL_VID  = 3'd1;
	localparam logic [2:0] SEL_PAL  = 3'd2;
	localparam logic [2:0] SEL_OBJ  = 3'd3;
	localparam logic [2:0] SEL_DIR  = 3'd4;

endpackage

// ----- design/lcd_timing_bitmap_renderer.sv -----
// channel | valid    | stall     | payload
// in      | in_valid | in_stall  | cmd address access_bytes write_data pixel_x
// out     | out_valid| out_stall | read_data pixel_color pixel_valid irq_raise
//         |          |           | frame_start error_code
// cfg     | cfg_we   | -         | cfg_data (vcount_target)
// Reads, register writes, line events, other pixels: memory read, then merge.
// Memory writes: word read, merge, then write-back of the modified word.
// Mode 4 pixels: video byte read, then palette read, then merge.
// One item is in flight at a time, so the bus read-modify-write never overlaps.
// Reset clears line counter, flags and control; memories are undefined.
// A stalled result holds in the output register; input stalls while busy.
module lcd_timing_bitmap_renderer #(
	parameter int VIDEO_WORDS   = ltbr_pkg::VideoWordsDef,
	parameter int LINE_WIDTH    = ltbr_pkg::LineWidthDef,
	parameter int VISIBLE_LINES = ltbr_pkg::VisibleLinesDef,
	parameter int TOTAL_LINES   = ltbr_pkg::TotalLinesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [26:0] address,
	input  logic [2:0]  access_bytes,
	input  logic [31:0] write_data,
	input  logic [7:0]  pixel_x,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic [15:0] pixel_color,
	output logic        pixel_valid,
	output logic [2:0]  irq_raise,
	output logic        frame_start,
	output logic [1:0]  error_code,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data
);
	import ltbr_pkg::*;

	localparam int VAW = $clog2(VIDEO_WORDS);
	localparam int VBYTES = VIDEO_WORDS * 4;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MRG  = 2'd1;
	localparam logic [1:0] ST_PAL  = 2'd2;
	localparam logic [1:0] ST_WB   = 2'd3;

	logic [31:0] video_mem [VIDEO_WORDS];
	logic [31:0] palette_mem [SmallWords];
	logic [31:0] object_mem [SmallWords];

	logic [1:0]  state_q;
	logic [7:0]  line_q, target_q;
	logic        vblank_q, hblank_q, blank_q, page_q;
	logic [2:0]  irqen_q, mode_q;

	// captured transaction
	logic [2:0]  cmd_s1, bytes_s1;
	logic [23:0] off_s1;
	logic [31:0] wdata_s1;
	logic        wr_s1;
	rd_ctl_t     ctl_s1;
	logic [31:0] vid_rd_s2, pal_rd_s2, obj_rd_s2;
	logic [31:0] dir_s1;
	logic [1:0]  err_s1;
	logic        pix_s1;   // mode-4 pixel in flight
	logic [2:0]  irq_s1;
	logic        frame_s1;
	logic        pvalid_s1;
	logic [15:0] color_s1;

	logic        accept;
	assign in_stall = (state_q != ST_IDLE) || (out_valid && out_stall);
	assign accept = in_valid && !in_stall;

	// decode of the incoming item
	logic        bad_size;
	logic [26:0] aaddr;
	logic [2:0]  region;
	logic [23:0] off;
	logic        in_range;
	logic [15:0] pix_idx;   // line*240+px
	logic [16:0] pix_boff;
	logic [VAW-1:0] rd_addr;
	logic [7:0]  pal_addr;
	logic [31:0] mask_in;

	always_comb begin
		bad_size = !(access_bytes == 3'd1 || access_bytes == 3'd2 || access_bytes == 3'd4);
		aaddr = address;
		if (access_bytes == 3'd2) aaddr[0] = 1'b0;
		if (access_bytes == 3'd4) aaddr[1:0] = 2'b00;
		region = aaddr[26:24];
		off = aaddr[23:0];
		pix_idx = 16'(line_q) * 16'(LINE_WIDTH) + 16'(pixel_x);
		if (mode_q == 3'd3)
			pix_boff = {pix_idx, 1'b0};
		else
			pix_boff = 17'(pix_idx) + (page_q ? 17'(PageBytes) : 17'd0);
		unique case (region)
			REG_VIDEO: in_range = 32'(off) < 32'(VBYTES);
			REG_PAL, REG_OBJ: in_range = off < 24'(SmallWords * 4);
			default: in_range = 1'b0;
		endcase
		if (cmd == CMD_PIXEL)
			rd_addr = VAW'(pix_boff >> 2);
		else
			rd_addr = VAW'(off >> 2);
		pal_addr = off[9:2];
		unique case (access_bytes)
			3'd1: mask_in = 32'h0000_00FF;
			3'd2: mask_in = 32'h0000_FFFF;
			default: mask_in = 32'hFFFF_FFFF;
		endcase
	end

	// status word from current state
	logic [15:0] status_w;
	assign status_w = {line_q, 2'b00, irqen_q, (line_q == target_q), hblank_q, vblank_q};

	// memory read ports (registered data)
	logic        pal_rd_en;
	logic [7:0]  pal_rd_a;
	logic [7:0]  px_byte;
	always_comb begin
		unique case (ctl_s1.lane)
			2'd0: px_byte = vid_rd_s2[7:0];
			2'd1: px_byte = vid_rd_s2[15:8];
			2'd2: px_byte = vid_rd_s2[23:16];
			default: px_byte = vid_rd_s2[31:24];
		endcase
		pal_rd_en = (state_q == ST_MRG) && pix_s1;
		pal_rd_a = pal_rd_en ? {1'b0, px_byte[7:1]} : pal_addr;
	end

	// write-back merge
	logic [31:0] old_w, wmask, new_w;
	always_comb begin
		unique case (ctl_s1.sel)
			SEL_PAL: old_w = pal_rd_s2;
			SEL_OBJ: old_w = obj_rd_s2;
			default: old_w = vid_rd_s2;
		endcase
		unique case (bytes_s1)
			3'd1: wmask = 32'h0000_00FF;
			3'd2: wmask = 32'h0000_FFFF;
			default: wmask = 32'hFFFF_FFFF;
		endcase
		wmask = wmask << {off_s1[1:0], 3'b000};
		new_w = (old_w & ~wmask) | ((wdata_s1 << {off_s1[1:0], 3'b000}) & wmask);
	end

	always_ff @(posedge clk) begin
		if (accept || pal_rd_en) begin
			pal_rd_s2 <= palette_mem[pal_rd_a];
		end
		if (accept) begin
			vid_rd_s2 <= video_mem[rd_addr];
			obj_rd_s2 <= object_mem[pal_addr];
		end
		if (state_q == ST_WB && wr_s1) begin
			unique case (ctl_s1.sel)
				SEL_VID: video_mem[VAW'(off_s1 >> 2)] <= new_w;
				SEL_PAL: palette_mem[off_s1[9:2]] <= new_w;
				SEL_OBJ: object_mem[off_s1[9:2]] <= new_w;
				default: ;
			endcase
		end
	end

	// merge of read data
	logic [31:0] src_w, shifted, rd_final;
	logic [15:0] pal_half;
	always_comb begin
		unique case (ctl_s1.sel)
			SEL_PAL: src_w = pal_rd_s2;
			SEL_OBJ: src_w = obj_rd_s2;
			SEL_DIR: src_w = dir_s1;
			default: src_w = vid_rd_s2;
		endcase
		shifted = (ctl_s1.sel == SEL_DIR) ? src_w : src_w >> {ctl_s1.lane, 3'b000};
		unique case (ctl_s1.bytes)
			3'd1: rd_final = shifted & 32'h0000_00FF;
			3'd2: rd_final = shifted & 32'h0000_FFFF;
			default: rd_final = shifted;
		endcase
		if (ctl_s1.sel == SEL_NONE) rd_final = '0;
		pal_half = ctl_s1.bytes[0] ? pal_rd_s2[31:16] : pal_rd_s2[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			line_q <= '0;
			target_q <= '0;
			vblank_q <= 1'b0;
			hblank_q <= 1'b0;
			blank_q <= 1'b0;
			page_q <= 1'b0;
			irqen_q <= '0;
			mode_q <= '0;
		end else begin
			if (cfg_we) target_q <= cfg_data;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MRG;
						unique case (cmd)
							CMD_WRITE: begin
								if (!bad_size && region == REG_IO) begin
									if (off == 24'd0) begin
										mode_q <= write_data[2:0];
										page_q <= write_data[4];
										blank_q <= write_data[7];
									end else if (off == 24'd4) begin
										irqen_q <= write_data[5:3];
									end
								end
							end
							CMD_LSTART: hblank_q <= 1'b0;
							CMD_HBLANK: hblank_q <= 1'b1;
							CMD_LFIN: begin
								hblank_q <= 1'b0;
								if (line_q + 8'd1 == 8'(VISIBLE_LINES)) vblank_q <= 1'b1;
								if (line_q + 8'd1 == 8'(TOTAL_LINES - 1)) vblank_q <= 1'b0;
								if (32'(line_q) + 1 >= TOTAL_LINES) begin
									line_q <= '0;
									vblank_q <= 1'b0;
								end else begin
									line_q <= line_q + 8'd1;
								end
							end
							default: ;
						endcase
					end
				end
				ST_MRG: begin
					if (pix_s1) state_q <= ST_PAL;
					else if (wr_s1) state_q <= ST_WB;
					else begin
						state_q <= ST_IDLE;
						out_valid <= 1'b1;
					end
				end
				ST_PAL, ST_WB: begin
					state_q <= ST_IDLE;
					out_valid <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// capture of the item and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
			bytes_s1 <= access_bytes;
			off_s1 <= off;
			wdata_s1 <= write_data;
			wr_s1 <= 1'b0;
			pix_s1 <= 1'b0;
			ctl_s1 <= '{sel: SEL_NONE, lane: off[1:0], bytes: access_bytes};
			dir_s1 <= '0;
			err_s1 <= ERR_OK;
			irq_s1 <= '0;
			frame_s1 <= 1'b0;
			pvalid_s1 <= 1'b0;
			color_s1 <= '0;
			unique case (cmd)
				CMD_READ, CMD_WRITE: begin
					if (bad_size) begin
						err_s1 <= ERR_ADDR;
					end else if (region == REG_IO) begin
						if (cmd == CMD_WRITE) begin
							if (off == 24'd0)
								err_s1 <= (write_data[2:1] == 2'b11) ? ERR_MODE : ERR_OK;
							else if (off != 24'd4)
								err_s1 <= ERR_ADDR;
						end else if (off == 24'd4) begin
							ctl_s1.sel <= SEL_DIR;
							dir_s1 <= 32'(status_w) & mask_in;
						end else if (off == 24'd6) begin
							ctl_s1.sel <= SEL_DIR;
							dir_s1 <= 32'(line_q) & mask_in;
						end else begin
							err_s1 <= ERR_ADDR;
						end
					end else if (!in_range) begin
						err_s1 <= ERR_ADDR;
					end else begin
						wr_s1 <= (cmd == CMD_WRITE);
						unique case (region)
							REG_PAL: ctl_s1.sel <= SEL_PAL;
							REG_OBJ: ctl_s1.sel <= SEL_OBJ;
							default: ctl_s1.sel <= SEL_VID;
						endcase
					end
				end
				CMD_LSTART: irq_s1 <= {(line_q == target_q), 2'b00};
				CMD_HBLANK: irq_s1 <= 3'b010;
				CMD_LFIN: begin
					irq_s1 <= {2'b00, line_q + 8'd1 == 8'(VISIBLE_LINES)};
					frame_s1 <= (32'(line_q) + 1 >= TOTAL_LINES);
				end
				CMD_PIXEL: begin
					if (32'(line_q) < VISIBLE_LINES) begin
						if (32'(pixel_x) >= LINE_WIDTH) begin
							err_s1 <= ERR_ADDR;
						end else if (blank_q) begin
							color_s1 <= 16'hFFFF;
							pvalid_s1 <= 1'b1;
						end else if (mode_q == 3'd3) begin
							pvalid_s1 <= 1'b1;
							ctl_s1 <= '{sel: SEL_VID, lane: pix_boff[1:0], bytes: 3'd2};
						end else if (mode_q == 3'd4) begin
							pvalid_s1 <= 1'b1;
							pix_s1 <= 1'b1;
							ctl_s1 <= '{sel: SEL_VID, lane: pix_boff[1:0], bytes: 3'd1};
						end else begin
							err_s1 <= ERR_UNSUP;
						end
					end
				end
				default: ;
			endcase
		end else if (state_q == ST_MRG && pix_s1) begin
			// bytes field reused for the halfword select of the palette word
			ctl_s1.bytes <= {2'b00, px_byte[0]};
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q != ST_IDLE && state_q != ST_WB && !(state_q == ST_MRG && (pix_s1 || wr_s1))) begin
			read_data <= (cmd_s1 == CMD_READ) ? rd_final : 32'd0;
			if (state_q == ST_PAL)
				pixel_color <= pal_half;
			else if (cmd_s1 == CMD_PIXEL && ctl_s1.sel == SEL_VID)
				pixel_color <= rd_final[15:0];
			else
				pixel_color <= color_s1;
			pixel_valid <= pvalid_s1;
			irq_raise <= irq_s1;
			frame_start <= frame_s1;
			error_code <= err_s1;
		end else if (state_q == ST_WB) begin
			read_data <= '0;
			pixel_color <= '0;
			pixel_valid <= 1'b0;
			irq_raise <= '0;
			frame_start <= 1'b0;
			error_code <= err_s1;
		end
	end

endmodule
